>>> rtl/core/core_pick_with_pressure_spread_core_assert.svh
// ----------------------------------------------------------------------------
// Core picker assertion macros
// Short forms for the concurrent checks at the end of the top level.
// Each macro expects clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CORE_PICK_WITH_PRESSURE_SPREAD_CORE_ASSERT_SVH
`define CORE_PICK_WITH_PRESSURE_SPREAD_CORE_ASSERT_SVH

// Same-cycle implication
`define CPPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CPPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core picker package
// Widths, codes and record types shared by the core picker modules.
// ----------------------------------------------------------------------------
package cpps_pkg;

  localparam int NUM_CORES      = 8;
  localparam int PRESSURE_LIMIT = 8;

  localparam int CORE_W   = $clog2(NUM_CORES);
  localparam int MASK_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int SCORE_W  = 24;
  localparam int CAP_W    = 11;
  localparam int DEMAND_W = 11;
  localparam int PRESS_W  = 4;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CAP_W-1:0]   FULL_CAPACITY = CAP_W'(1024);
  localparam logic [PRESS_W-1:0] PRESS_LIMIT   = PRESS_W'(PRESSURE_LIMIT);

  // Item function codes
  localparam logic [FUNC_W-1:0] FN_PICK = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_WINDOW = 1'd1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CAP_W-1:0]   capacity;
  } sc_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last_pick;
    logic [PRESS_W-1:0] count;
  } pr_entry_t;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic              masked;
    logic [CORE_W-1:0] core;
  } eval_ctrl_t;

  typedef struct packed {
    logic               ok;
    logic [CORE_W-1:0]  core;
    logic [PRESS_W-1:0] press;
  } eval_res_t;

endpackage

>>> rtl/core/cpps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core picker request channel
// Valid/ready channel carrying one pick, load or tick item.
// ----------------------------------------------------------------------------
interface cpps_req_if;
  import cpps_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [MASK_W-1:0]   allowed_mask;
  logic [DEMAND_W-1:0] demand;
  logic                peak_pick;
  logic [2:0]          core_index;
  logic [SCORE_W-1:0]  core_score;
  logic [CAP_W-1:0]    core_capacity;

  modport source (
    output valid, func, allowed_mask, demand, peak_pick, core_index, core_score,
           core_capacity,
    input  ready
  );

  modport sink (
    input  valid, func, allowed_mask, demand, peak_pick, core_index, core_score,
           core_capacity,
    output ready
  );
endinterface

>>> rtl/core/cpps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core picker response channel
// Valid/ready channel carrying one result item per request item.
// ----------------------------------------------------------------------------
interface cpps_rsp_if;
  import cpps_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [CORE_W-1:0] chosen_core;

  modport source (
    output valid, found, chosen_core,
    input  ready
  );

  modport sink (
    input  valid, found, chosen_core,
    output ready
  );
endinterface

>>> rtl/core/cpps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cpps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/cpps_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core picker scan evaluator
// Scores one core entry per cycle and keeps the best and fallback candidates.
// ----------------------------------------------------------------------------
module cpps_eval (
  input  logic                          clk,
  input  logic                          rst,
  input  cpps_pkg::eval_ctrl_t          ctrl,
  input  logic                          peak,
  input  logic [cpps_pkg::DEMAND_W-1:0] demand,
  input  logic                          spread_enable,
  input  logic [cpps_pkg::TIME_W-1:0]   thr,
  input  cpps_pkg::sc_entry_t           sc,
  input  cpps_pkg::pr_entry_t           pr,
  output logic                          clr_we,
  output cpps_pkg::pr_entry_t           clr_data,
  output cpps_pkg::eval_res_t           res
);
  import cpps_pkg::*;

  logic [SCORE_W-1:0] eff_score;
  logic [CAP_W-1:0]   eff_cap;
  logic [TIME_W-1:0]  diff;
  logic               active;
  logic               expired;
  logic [PRESS_W-1:0] press;
  logic               fits;
  logic               fb_take;
  logic               best_take;
  logic               best_gt;
  logic               best_lt;
  logic               best_eq;

  logic               fb_ok;
  logic [SCORE_W-1:0] fb_score;
  logic [PRESS_W-1:0] fb_press;
  logic [CORE_W-1:0]  fb_core;
  logic               best_ok;
  logic [SCORE_W-1:0] lead_score;
  logic [PRESS_W-1:0] best_press;
  logic [CORE_W-1:0]  best_core;

  always_comb begin
    eff_score = (sc.score == '0) ? SCORE_W'(ctrl.core) + SCORE_W'(1) : sc.score;
    eff_cap   = (sc.capacity == '0) ? FULL_CAPACITY : sc.capacity;
    // thr already holds now - window, so the wrapped difference is one subtract
    diff      = thr - pr.last_pick;
    active    = spread_enable && (pr.count != '0);
    expired   = !diff[TIME_W-1];
    if (active && !expired) begin
      press = (pr.count > PRESS_LIMIT) ? PRESS_LIMIT : pr.count;
    end else begin
      press = '0;
    end
    fits      = peak || (demand == '0) || (eff_cap >= demand);
    fb_take   = !fb_ok || (eff_score > fb_score) ||
                ((eff_score == fb_score) && (press <= fb_press));
    best_gt   = eff_score > lead_score;
    best_lt   = eff_score < lead_score;
    best_eq   = (eff_score == lead_score) && (press <= best_press);
    best_take = fits && (!best_ok || (peak ? (best_gt || best_eq) : (best_lt || best_eq)));
  end

  // Drop stale pressure of a scanned core back to memory
  assign clr_we             = ctrl.step && ctrl.masked && active && expired;
  assign clr_data.last_pick = pr.last_pick;
  assign clr_data.count     = '0;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      fb_ok   <= 1'b0;
      best_ok <= 1'b0;
    end else if (ctrl.step && ctrl.masked) begin
      if (fb_take) begin
        fb_ok <= 1'b1;
      end
      if (best_take) begin
        best_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.masked) begin
      if (fb_take) begin
        fb_score <= eff_score;
        fb_press <= press;
        fb_core  <= ctrl.core;
      end
      if (best_take) begin
        lead_score <= eff_score;
        best_press <= press;
        best_core  <= ctrl.core;
      end
    end
  end

  assign res.ok    = best_ok || fb_ok;
  assign res.core  = best_ok ? best_core : fb_core;
  assign res.press = best_ok ? best_press : fb_press;

endmodule

>>> rtl/core/core_pick_with_pressure_spread_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core picker with pressure spreading
// Picks a core per request from per-core score, capacity and pressure memories.
// ----------------------------------------------------------------------------
// Load and tick items are acted on when accepted. A pick item walks all
// NUM_CORES entries of the score/capacity and pressure memories through their
// single read port, one entry per cycle, then commits the pressure update of
// the chosen core. No new item is accepted until the picker is back in idle;
// the done state waits there while the result register is stalled.
// Memory entries read as zero until first written; no clearing pass is run.
module core_pick_with_pressure_spread_core (
  input  logic                            clk,
  input  logic                            rst,
  cpps_req_if.sink                        req,
  cpps_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [cpps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cpps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cpps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam logic [CORE_W-1:0] LAST_CORE = CORE_W'(NUM_CORES - 1);

  state_t              state;
  logic [CORE_W-1:0]   scan_idx;
  logic [TIME_W-1:0]   now_ticks;
  logic                spread_enable;
  logic [WIN_W-1:0]    spread_window;
  logic [TIME_W-1:0]   thr;
  logic [MASK_W-1:0]   pick_mask;
  logic [DEMAND_W-1:0] pick_demand;
  logic                pick_peak;
  logic [NUM_CORES-1:0] sc_vld;
  logic [NUM_CORES-1:0] pr_vld;
  logic                sc_vld_q;
  logic                pr_vld_q;
  logic                rsp_valid;
  logic                rsp_found;
  logic [CORE_W-1:0]   rsp_core;

  logic                accept;
  logic                pick_acc;
  logic                out_free;
  logic                rd_en;
  logic [CORE_W-1:0]   rd_addr;
  logic [WIN_W-1:0]    win_eff;
  logic                load_ok;
  logic                commit_we;
  logic [PRESS_W-1:0]  press_next;
  logic                pr_we;
  logic [CORE_W-1:0]   pr_waddr;
  pr_entry_t           pr_wdata;
  sc_entry_t           sc_wdata;
  sc_entry_t           sc_rdata;
  pr_entry_t           pr_rdata;
  sc_entry_t           sc_ent;
  pr_entry_t           pr_ent;
  eval_ctrl_t          ev_ctrl;
  eval_res_t           ev_res;
  logic                clr_we;
  pr_entry_t           clr_data;
  logic                scanning;
  logic                scan_more;

  assign out_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept   = req.valid && req.ready;
  assign pick_acc = accept && (req.func == FN_PICK);
  assign load_ok  = 32'(req.core_index) < NUM_CORES;
  assign win_eff  = (spread_window == '0) ? WIN_W'(1) : spread_window;

  assign scanning  = (state == ST_SCAN);
  assign scan_more = scanning && (scan_idx != LAST_CORE);

  // Read one entry ahead of the one being evaluated
  assign rd_en   = pick_acc || (state == ST_SCAN);
  assign rd_addr = (state == ST_IDLE) ? '0 : scan_idx + CORE_W'(1);

  assign sc_wdata.score    = req.core_score;
  assign sc_wdata.capacity = req.core_capacity;

  assign press_next = (ev_res.press < PRESS_LIMIT) ? ev_res.press + PRESS_W'(1)
                                                   : ev_res.press;
  assign commit_we  = (state == ST_DONE) && out_free && ev_res.ok && spread_enable;
  assign pr_we      = commit_we || clr_we;
  assign pr_waddr   = commit_we ? ev_res.core : scan_idx;
  always_comb begin
    if (commit_we) begin
      pr_wdata.last_pick = now_ticks;
      pr_wdata.count     = press_next;
    end else begin
      pr_wdata = clr_data;
    end
  end

  cpps_ram #(
    .WIDTH ($bits(sc_entry_t)),
    .DEPTH (NUM_CORES)
  ) u_sc_ram (
    .clk   (clk),
    .we    (accept && (req.func == FN_LOAD) && load_ok),
    .waddr (req.core_index[CORE_W-1:0]),
    .wdata (sc_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (sc_rdata)
  );

  cpps_ram #(
    .WIDTH ($bits(pr_entry_t)),
    .DEPTH (NUM_CORES)
  ) u_pr_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pr_rdata)
  );

  assign sc_ent = sc_vld_q ? sc_rdata : '0;
  assign pr_ent = pr_vld_q ? pr_rdata : '0;

  assign ev_ctrl.clear  = pick_acc;
  assign ev_ctrl.step   = (state == ST_SCAN);
  assign ev_ctrl.masked = pick_mask[scan_idx];
  assign ev_ctrl.core   = scan_idx;

  cpps_eval u_eval (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ev_ctrl),
    .peak          (pick_peak),
    .demand        (pick_demand),
    .spread_enable (spread_enable),
    .thr           (thr),
    .sc            (sc_ent),
    .pr            (pr_ent),
    .clr_we        (clr_we),
    .clr_data      (clr_data),
    .res           (ev_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan_idx      <= '0;
      now_ticks     <= '0;
      spread_enable <= 1'b1;
      spread_window <= WIN_W'(16);
      sc_vld        <= '0;
      pr_vld        <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SPREAD_ENABLE: spread_enable <= cfg_wdata[0];
          CFG_SPREAD_WINDOW: spread_window <= cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end

      if (accept && (req.func == FN_TICK)) begin
        now_ticks <= now_ticks + TIME_W'(1);
      end
      if (accept && (req.func == FN_LOAD) && load_ok) begin
        sc_vld[req.core_index[CORE_W-1:0]] <= 1'b1;
      end
      if (pr_we) begin
        pr_vld[pr_waddr] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (pick_acc) begin
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx == LAST_CORE) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= scan_idx + CORE_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Hold the result until taken
      if (accept && (req.func != FN_PICK)) begin
        rsp_valid <= 1'b1;
      end else if ((state == ST_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pick_acc) begin
      thr         <= now_ticks - TIME_W'(win_eff);
      pick_mask   <= req.allowed_mask;
      pick_demand <= req.demand;
      pick_peak   <= req.peak_pick;
    end
    if (rd_en) begin
      sc_vld_q <= sc_vld[rd_addr];
      pr_vld_q <= pr_vld[rd_addr];
    end
    if (accept && (req.func != FN_PICK)) begin
      rsp_found <= 1'b0;
      rsp_core  <= '0;
    end else if ((state == ST_DONE) && out_free) begin
      rsp_found <= ev_res.ok;
      rsp_core  <= ev_res.ok ? ev_res.core : '0;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.chosen_core = rsp_core;

`include "core_pick_with_pressure_spread_core_assert.svh"

  `CPPS_ASSERT_NXT(a_pick_starts_scan, pick_acc, scanning && (scan_idx == '0), "bad scan start")
  `CPPS_ASSERT_NXT(a_scan_step, scan_more, scanning && (scan_idx == $past(rd_addr)), "scan slip")
  `CPPS_ASSERT_IMP(a_no_rw_collision, pr_we && rd_en, pr_waddr != rd_addr, "pressure rw clash")

endmodule
